FILE: rtl/qmm_pkg.sv
// Shared types and constants for the quad motor mixer.
`default_nettype none
package qmm_pkg;

  // Field widths
  localparam int unsigned THR_W  = 12;
  localparam int unsigned TERM_W = 13;
  localparam int unsigned MV_W   = 16;
  localparam int unsigned DUTY_W = 15;
  localparam int unsigned PROD_W = THR_W + MV_W;
  localparam int unsigned QUOT_W = MV_W;
  // Mix range: unsigned quotient plus three signed terms, with sign
  localparam int unsigned MIX_W  = QUOT_W + 2;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Divider pipeline shape
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = QUOT_W / DIV_STEPS;

  // Register reset values
  localparam logic [DUTY_W-1:0] PWM_MAX_RST  = 15'd1000;
  localparam logic [DUTY_W-1:0] PWM_MIN_RST  = 15'd0;
  localparam logic [DUTY_W-1:0] IDLE_LVL_RST = 15'd40;
  localparam logic [MV_W-1:0]   REF_MV_RST   = 16'd4200;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PWM_MAX  = 2'd0,
    REG_PWM_MIN  = 2'd1,
    REG_IDLE_LVL = 2'd2,
    REG_REF_MV   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FLY  = 2'd1,
    MODE_STOP = 2'd2
  } mode_e;

  // Attitude terms and mode riding alongside the throttle math
  typedef struct packed {
    logic signed [TERM_W-1:0] pitch;
    logic signed [TERM_W-1:0] roll;
    logic signed [TERM_W-1:0] yaw;
    mode_e                    mode;
  } side_t;

  // Live configuration seen by the datapath
  typedef struct packed {
    logic [DUTY_W-1:0] pwm_max;
    logic [DUTY_W-1:0] pwm_min;
    logic [DUTY_W-1:0] idle_level;
    logic [MV_W-1:0]   reference_mv;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/qmm_mult.sv
// Throttle times reference voltage, one registered stage.
`default_nettype none
module qmm_mult (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [qmm_pkg::THR_W-1:0]     thr_i,
  input  wire logic [qmm_pkg::MV_W-1:0]      bat_i,
  input  wire logic [qmm_pkg::MV_W-1:0]      ref_i,
  input  wire qmm_pkg::side_t                side_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [qmm_pkg::PROD_W-1:0]         prod_o,
  output logic [qmm_pkg::MV_W-1:0]           bat_o,
  output qmm_pkg::side_t                     side_o
);

  logic                        valid_q;
  logic [qmm_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic [qmm_pkg::MV_W-1:0]    bat_q;
  qmm_pkg::side_t              side_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign prod_d     = qmm_pkg::PROD_W'(thr_i) * qmm_pkg::PROD_W'(ref_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q <= prod_d;
      bat_q  <= bat_i;
      side_q <= side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign prod_o      = prod_q;
  assign bat_o       = bat_q;
  assign side_o      = side_q;

endmodule
`default_nettype wire

FILE: rtl/qmm_div.sv
// Pipelined restoring divider with saturation, two quotient bits per stage.
`default_nettype none
module qmm_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [qmm_pkg::PROD_W-1:0]    prod_i,
  input  wire logic [qmm_pkg::MV_W-1:0]      bat_i,
  input  wire qmm_pkg::side_t                side_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [qmm_pkg::QUOT_W-1:0]         quot_o,
  output qmm_pkg::side_t                     side_o
);

  localparam int unsigned N  = qmm_pkg::DIV_STAGES;
  localparam int unsigned MW = qmm_pkg::MV_W;
  localparam int unsigned QW = qmm_pkg::QUOT_W;

  // Index 0 is the entry stage, 1..N the divide stages
  logic [N:0]    valid_q;
  logic [N+1:0]  rdy;
  logic [MW-1:0] rem_q  [N+1];
  logic [QW-1:0] sh_q   [N+1];
  logic [MW-1:0] bat_q  [N+1];
  logic          sat_q  [N+1];
  qmm_pkg::side_t side_q [N+1];

  logic          sat_d;

  assign rdy[N+1] = out_ready_i;
  for (genvar g = 0; g <= N; g++) begin : g_rdy
    assign rdy[g] = !valid_q[g] || rdy[g+1];
  end
  assign in_ready_o = rdy[0];

  // Quotient overflows 16 bits when the high part already reaches the divisor;
  // a zero divisor always lands here.
  assign sat_d = (MW'(prod_i[qmm_pkg::PROD_W-1:QW]) >= bat_i) ? 1'b1 : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      rem_q[0]  <= MW'(prod_i[qmm_pkg::PROD_W-1:QW]);
      sh_q[0]   <= prod_i[QW-1:0];
      bat_q[0]  <= bat_i;
      sat_q[0]  <= sat_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar g = 1; g <= N; g++) begin : g_stage
    logic [MW-1:0] rem_d;
    logic [QW-1:0] sh_d;

    always_comb begin
      logic [MW:0] trial;
      rem_d = rem_q[g-1];
      sh_d  = sh_q[g-1];
      trial = '0;
      for (int k = 0; k < int'(qmm_pkg::DIV_STEPS); k++) begin
        trial = {rem_d, sh_d[QW-1]};
        if (trial >= {1'b0, bat_q[g-1]}) begin
          rem_d = MW'(trial - {1'b0, bat_q[g-1]});
          sh_d  = {sh_d[QW-2:0], 1'b1};
        end else begin
          rem_d = trial[MW-1:0];
          sh_d  = {sh_d[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (rdy[g]) begin
        valid_q[g] <= valid_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[g] && valid_q[g-1]) begin
        rem_q[g]  <= rem_d;
        sh_q[g]   <= sh_d;
        bat_q[g]  <= bat_q[g-1];
        sat_q[g]  <= sat_q[g-1];
        side_q[g] <= side_q[g-1];
      end
    end
  end

  assign out_valid_o = valid_q[N];
  assign quot_o      = sat_q[N] ? '1 : sh_q[N];
  assign side_o      = side_q[N];

endmodule
`default_nettype wire

FILE: rtl/qmm_mix.sv
// X-frame mix and mode select, then clamp to the duty window.
`default_nettype none
module qmm_mix (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire qmm_pkg::cfg_t                 cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [qmm_pkg::QUOT_W-1:0]    thr_i,
  input  wire qmm_pkg::side_t                side_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [qmm_pkg::DUTY_W-1:0]         duty_o [4]
);

  localparam int unsigned XW = qmm_pkg::MIX_W;
  localparam int unsigned DW = qmm_pkg::DUTY_W;

  logic                 mix_valid_q, clp_valid_q;
  logic                 mix_rdy, clp_rdy;
  logic signed [XW-1:0] mix_q [4];
  logic signed [XW-1:0] mix_d [4];
  logic [DW-1:0]        clp_q [4];
  logic [DW-1:0]        clp_d [4];

  assign clp_rdy    = !clp_valid_q || out_ready_i;
  assign mix_rdy    = !mix_valid_q || clp_rdy;
  assign in_ready_o = mix_rdy;

  // Entries: mix one, mix two, mix three, mix four
  always_comb begin
    logic signed [XW-1:0] t, p, r, y;
    t = XW'(signed'({1'b0, thr_i}));
    p = XW'(side_i.pitch);
    r = XW'(side_i.roll);
    y = XW'(side_i.yaw);
    priority if (side_i.mode == qmm_pkg::MODE_FLY) begin
      mix_d[0] = t + p + r + y;
      mix_d[1] = t - p - r + y;
      mix_d[2] = t - p + r - y;
      mix_d[3] = t + p - r - y;
    end else if (side_i.mode == qmm_pkg::MODE_IDLE) begin
      for (int i = 0; i < 4; i++) mix_d[i] = XW'(signed'({1'b0, cfg_i.idle_level}));
    end else begin
      // stop, and the unused code, drive zero
      for (int i = 0; i < 4; i++) mix_d[i] = '0;
    end
  end

  always_comb begin
    logic signed [XW-1:0] hi, lo;
    hi = XW'(signed'({1'b0, cfg_i.pwm_max}));
    lo = XW'(signed'({1'b0, cfg_i.pwm_min}));
    for (int i = 0; i < 4; i++) begin
      // lower bound wins on an inverted window
      if (mix_q[i] < lo) begin
        clp_d[i] = cfg_i.pwm_min;
      end else if (mix_q[i] > hi) begin
        clp_d[i] = (hi < lo) ? cfg_i.pwm_min : cfg_i.pwm_max;
      end else begin
        clp_d[i] = DW'(mix_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_valid_q <= 1'b0;
      clp_valid_q <= 1'b0;
    end else begin
      if (mix_rdy) mix_valid_q <= in_valid_i;
      if (clp_rdy) clp_valid_q <= mix_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mix_rdy && in_valid_i) mix_q <= mix_d;
    if (clp_rdy && mix_valid_q) clp_q <= clp_d;
  end

  assign out_valid_o = clp_valid_q;
  assign duty_o      = clp_q;

endmodule
`default_nettype wire

FILE: rtl/quad_motor_mixer.sv
// Top level of the quad motor mixer: config registers and pipeline wiring.
//
// Usage: one beat on the slave stream carries throttle, pitch, roll and yaw
// terms and the battery voltage in tdata, and the flight mode in tuser. One
// beat comes out on the master stream for every beat taken: four clamped
// channel duties. The throttle is scaled by reference_mv / battery_mv
// (truncating, saturating at 65535), mixed for an X frame and clamped to
// the pwm_min..pwm_max window; idle mode drives idle_level and stop mode
// zero, both clamped.
// An accepted input beat passes one multiply stage, one divider entry stage,
// eight divide stages of two quotient bits each, one mix stage and one clamp
// stage. Throughput is one beat per cycle while the output is not
// stalled; the divider chain sets the depth. Every stage holds its own
// valid bit, so bubbles close up while the output is stalled, and the slave
// side keeps taking beats until the pipe is full. A stalled output beat
// holds steady. Reset empties the pipe and loads the register defaults
// (pwm_max 1000, pwm_min 0, idle 40, reference 4200 mV).
// Write configuration through cfg_we_i only while the pipe is empty.
`default_nettype none
module quad_motor_mixer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [qmm_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [qmm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Input stream
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // throttle[11:0], pitch_term[24:12], roll_term[37:25], yaw_term[50:38],
  // battery_mv[66:51], zero fill above
  input  wire logic [qmm_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // flight_mode[1:0]
  input  wire logic [1:0]                        s_axis_tuser_i,
  // Output stream
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // channel1_duty[14:0], channel2_duty[29:15], channel3_duty[44:30],
  // channel4_duty[59:45], zero fill above
  output logic [qmm_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o
);

  localparam int unsigned DW = qmm_pkg::DUTY_W;

  qmm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_max      <= qmm_pkg::PWM_MAX_RST;
      cfg_q.pwm_min      <= qmm_pkg::PWM_MIN_RST;
      cfg_q.idle_level   <= qmm_pkg::IDLE_LVL_RST;
      cfg_q.reference_mv <= qmm_pkg::REF_MV_RST;
    end else if (cfg_we_i) begin
      unique case (qmm_pkg::cfg_idx_e'(cfg_addr_i))
        qmm_pkg::REG_PWM_MAX:  cfg_q.pwm_max      <= cfg_wdata_i[DW-1:0];
        qmm_pkg::REG_PWM_MIN:  cfg_q.pwm_min      <= cfg_wdata_i[DW-1:0];
        qmm_pkg::REG_IDLE_LVL: cfg_q.idle_level   <= cfg_wdata_i[DW-1:0];
        qmm_pkg::REG_REF_MV:   cfg_q.reference_mv <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Unpack the input beat
  qmm_pkg::side_t side_in;
  assign side_in.pitch = signed'(s_axis_tdata_i[24:12]);
  assign side_in.roll  = signed'(s_axis_tdata_i[37:25]);
  assign side_in.yaw   = signed'(s_axis_tdata_i[50:38]);
  assign side_in.mode  = qmm_pkg::mode_e'(s_axis_tuser_i);

  logic                           mul_valid, mul_ready;
  logic [qmm_pkg::PROD_W-1:0]     mul_prod;
  logic [qmm_pkg::MV_W-1:0]       mul_bat;
  qmm_pkg::side_t                 mul_side;

  logic                           div_valid, div_ready;
  logic [qmm_pkg::QUOT_W-1:0]     div_quot;
  qmm_pkg::side_t                 div_side;

  logic [DW-1:0]                  duty [4];

  qmm_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .thr_i       (s_axis_tdata_i[11:0]),
    .bat_i       (s_axis_tdata_i[66:51]),
    .ref_i       (cfg_q.reference_mv),
    .side_i      (side_in),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .prod_o      (mul_prod),
    .bat_o       (mul_bat),
    .side_o      (mul_side)
  );

  qmm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .prod_i      (mul_prod),
    .bat_i       (mul_bat),
    .side_i      (mul_side),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .quot_o      (div_quot),
    .side_o      (div_side)
  );

  qmm_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .thr_i       (div_quot),
    .side_i      (div_side),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .duty_o      (duty)
  );

  // Route mixes to channels: ch1 <- mix three, ch2 <- mix one,
  // ch3 <- mix four, ch4 <- mix two
  assign m_axis_tdata_o = {4'b0000, duty[1], duty[3], duty[0], duty[2]};

endmodule
`default_nettype wire
